### rtl/core/mstl_pkg.sv
package mstl_pkg;

    localparam logic [2:0] ACT_LOAD_CHUNK_RUN = 3'd0;
    localparam logic [2:0] ACT_LOAD_TIME_RUN  = 3'd1;
    localparam logic [2:0] ACT_LOAD_SIZE      = 3'd2;
    localparam logic [2:0] ACT_LOAD_OFFSET    = 3'd3;
    localparam logic [2:0] ACT_QUERY          = 3'd4;

    localparam logic [2:0] CFG_UNIFORM_SIZE    = 3'd0;
    localparam logic [2:0] CFG_SAMPLE_COUNT    = 3'd1;
    localparam logic [2:0] CFG_CHUNK_RUNS_USED = 3'd2;
    localparam logic [2:0] CFG_TIME_RUNS_USED  = 3'd3;
    localparam logic [2:0] CFG_CHUNKS_USED     = 3'd4;
    localparam logic [2:0] CFG_FILE_BYTES      = 3'd5;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CHK,
        OP_RD_NXT,
        OP_EVAL,
        OP_STEP,
        OP_DIV,
        OP_CHUNK,
        OP_BASE2,
        OP_SUM,
        OP_SZ2,
        OP_TINIT,
        OP_TEV,
        OP_TADD,
        OP_FIN_OK,
        OP_FIN_BAD
    } t_op;

    typedef struct packed {
        logic fire;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic chk_bad;
        logic run_bad;
        logic hit;
        logic last_run;
        logic div_last;
        logic base_bad;
        logic uniform;
        logic sum_done;
        logic fin_bad;
        logic t_more;
        logic t_hit;
    } t_stat;

endpackage

### rtl/core/mstl_ctrl.sv
module mstl_ctrl
    import mstl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_action,
    input  logic       i_out_ready,
    input  t_stat      i_stat,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_C_RD0, S_C_RD1, S_C_EVAL, S_C_CMP, S_C_DIV, S_C_CHUNK,
        S_C_BASE, S_C_BASE2, S_SUM, S_RDSZ, S_SZ2, S_FCHK, S_T_RD, S_T_EV,
        S_T_ADD, S_OK, S_BAD
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   fire, out_free;
    t_op    op;

    assign o_in_ready  = (r_state == S_IDLE);
    assign fire        = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd.fire  = fire;
    assign o_cmd.op    = op;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        op          = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (fire && i_action == ACT_QUERY) n_state = S_CHK;
            end
            S_CHK: begin
                op      = OP_CHK;
                n_state = i_stat.chk_bad ? S_BAD : S_C_RD0;
            end
            S_C_RD0: n_state = S_C_RD1;
            S_C_RD1: begin
                op      = OP_RD_NXT;
                n_state = S_C_EVAL;
            end
            S_C_EVAL: begin
                op      = OP_EVAL;
                n_state = i_stat.run_bad ? S_BAD : S_C_CMP;
            end
            S_C_CMP: begin
                op = OP_STEP;
                if (i_stat.hit) n_state = S_C_DIV;
                else if (i_stat.last_run) n_state = S_BAD;
                else n_state = S_C_RD0;
            end
            S_C_DIV: begin
                op = OP_DIV;
                if (i_stat.div_last) n_state = S_C_CHUNK;
            end
            S_C_CHUNK: begin
                op      = OP_CHUNK;
                n_state = S_C_BASE;
            end
            S_C_BASE: n_state = S_C_BASE2;
            S_C_BASE2: begin
                op = OP_BASE2;
                if (i_stat.base_bad) n_state = S_BAD;
                else if (i_stat.uniform) n_state = S_RDSZ;
                else n_state = S_SUM;
            end
            S_SUM: begin
                op = OP_SUM;
                if (i_stat.sum_done) n_state = S_RDSZ;
            end
            S_RDSZ: n_state = S_SZ2;
            S_SZ2: begin
                op      = OP_SZ2;
                n_state = S_FCHK;
            end
            S_FCHK: begin
                op      = OP_TINIT;
                n_state = i_stat.fin_bad ? S_BAD : S_T_RD;
            end
            S_T_RD: n_state = i_stat.t_more ? S_T_EV : S_OK;
            S_T_EV: begin
                op      = OP_TEV;
                n_state = S_T_ADD;
            end
            S_T_ADD: begin
                op      = OP_TADD;
                n_state = i_stat.t_hit ? S_OK : S_T_RD;
            end
            S_OK: begin
                if (out_free) begin
                    op          = OP_FIN_OK;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_BAD: begin
                if (out_free) begin
                    op          = OP_FIN_BAD;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTH
    a_fin_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_FIN_OK || op == OP_FIN_BAD) |-> out_free)
        else $error("result written over a waiting item");
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_action == ACT_QUERY) |=> (r_state == S_CHK))
        else $error("query accepted but lookup not started");
    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(op) == OP_FIN_OK || $past(op) == OP_FIN_BAD))
        else $error("result valid without a finish step");
`endif

endmodule

### rtl/core/mstl_dp.sv
module mstl_dp
    import mstl_pkg::*;
#(
    parameter int CHUNK_RUN_DEPTH = 256,
    parameter int TIME_RUN_DEPTH  = 256,
    parameter int SIZE_DEPTH      = 4096,
    parameter int CHUNK_DEPTH     = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_slot,
    input  logic [31:0] i_word_first,
    input  logic [31:0] i_word_second,
    input  logic [63:0] i_offset_word,
    output t_stat       o_stat,
    output logic        o_found,
    output logic [63:0] o_sample_offset,
    output logic [31:0] o_sample_length,
    output logic [63:0] o_start_time
);

    localparam int CRW = (CHUNK_RUN_DEPTH > 1) ? $clog2(CHUNK_RUN_DEPTH) : 1;
    localparam int TRW = (TIME_RUN_DEPTH > 1) ? $clog2(TIME_RUN_DEPTH) : 1;
    localparam int SZW = (SIZE_DEPTH > 1) ? $clog2(SIZE_DEPTH) : 1;
    localparam int CKW = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;

    logic [63:0] crun_mem [CHUNK_RUN_DEPTH];
    logic [63:0] trun_mem [TIME_RUN_DEPTH];
    logic [31:0] size_mem [SIZE_DEPTH];
    logic [63:0] off_mem  [CHUNK_DEPTH];

    logic [31:0] r_uniform, r_sample_count;
    logic [8:0]  r_chunk_runs, r_time_runs;
    logic [10:0] r_chunks;
    logic [63:0] r_file_bytes;

    logic [31:0] r_idx, r_fc, r_per, r_rem, r_sz;
    logic [8:0]  r_i;
    logic [63:0] r_seen, r_prod, r_dend, r_quo, r_chunk, r_base, r_add, r_j, r_at, r_tacc;
    logic [5:0]  r_step;
    logic        r_pend, r_ovf, r_thit;
    logic [63:0] r_crun_rd, r_trun_rd, r_off_rd;
    logic [31:0] r_size_rd;
    logic        r_found;
    logic [63:0] r_out_off, r_out_time;
    logic [31:0] r_out_len;

    logic [31:0] cr_addr, tr_addr, sz_addr, ck_addr;
    logic [31:0] idx_minus;
    logic [63:0] chunk_m1, stop, idx64;
    logic [32:0] nf, div_t, div_d;
    logic        div_ge, cur_ok, nxt_ok, t_ok, idx_in_size, chunk_bad, t_hit;
    logic [31:0] t_cnt, t_dur;
    logic        fire;

    assign fire  = i_cmd.fire;
    assign idx64 = {32'd0, r_idx};

    // read addresses
    assign cr_addr  = 32'(r_i) + ((i_cmd.op == OP_RD_NXT) ? 32'd1 : 32'd0);
    assign tr_addr  = 32'(r_i);
    assign sz_addr  = (i_cmd.op == OP_SUM) ? r_j[31:0] : r_idx;
    assign chunk_m1 = r_chunk - 64'd1;
    assign ck_addr  = chunk_m1[31:0];

    always_ff @(posedge i_clk) begin
        if (fire && i_action == ACT_LOAD_CHUNK_RUN && i_slot < 32'(CHUNK_RUN_DEPTH))
            crun_mem[i_slot[CRW-1:0]] <= {i_word_first, i_word_second};
        r_crun_rd <= crun_mem[cr_addr[CRW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_action == ACT_LOAD_TIME_RUN && i_slot < 32'(TIME_RUN_DEPTH))
            trun_mem[i_slot[TRW-1:0]] <= {i_word_first, i_word_second};
        r_trun_rd <= trun_mem[tr_addr[TRW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_action == ACT_LOAD_SIZE && i_slot < 32'(SIZE_DEPTH))
            size_mem[i_slot[SZW-1:0]] <= i_word_first;
        r_size_rd <= size_mem[sz_addr[SZW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_action == ACT_LOAD_OFFSET && i_slot < 32'(CHUNK_DEPTH))
            off_mem[i_slot[CKW-1:0]] <= i_offset_word;
        r_off_rd <= off_mem[ck_addr[CKW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uniform      <= '0;
            r_sample_count <= '0;
            r_chunk_runs   <= '0;
            r_time_runs    <= '0;
            r_chunks       <= '0;
            r_file_bytes   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_UNIFORM_SIZE:    r_uniform      <= i_cfg_data[31:0];
                CFG_SAMPLE_COUNT:    r_sample_count <= i_cfg_data[31:0];
                CFG_CHUNK_RUNS_USED: r_chunk_runs   <= i_cfg_data[8:0];
                CFG_TIME_RUNS_USED:  r_time_runs    <= i_cfg_data[8:0];
                CFG_CHUNKS_USED:     r_chunks       <= i_cfg_data[10:0];
                CFG_FILE_BYTES:      r_file_bytes   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cur_ok      = 32'(r_i) < 32'(CHUNK_RUN_DEPTH);
        nxt_ok      = (32'(r_i) + 32'd1) < 32'(CHUNK_RUN_DEPTH);
        t_ok        = 32'(r_i) < 32'(TIME_RUN_DEPTH);
        idx_in_size = idx64 < 64'(SIZE_DEPTH);
        stop        = idx_in_size ? idx64 : 64'(SIZE_DEPTH);
        // next run's first chunk, or one past the last chunk for the last run
        if ((10'(r_i) + 10'd1) < 10'(r_chunk_runs))
            nf = nxt_ok ? {1'b0, r_crun_rd[63:32]} : 33'd0;
        else
            nf = 33'(r_chunks) + 33'd1;
        div_t     = {r_rem, r_dend[63]};
        div_d     = {1'b0, r_per};
        div_ge    = div_t >= div_d;
        chunk_bad = (r_chunk == 64'd0) || (r_chunk > 64'(r_chunks))
                    || (chunk_m1 >= 64'(CHUNK_DEPTH));
        t_cnt     = t_ok ? r_trun_rd[63:32] : 32'd0;
        t_dur     = t_ok ? r_trun_rd[31:0] : 32'd0;
        t_hit     = idx64 < (r_seen + {32'd0, t_cnt});
        idx_minus = r_idx - r_seen[31:0];

        o_stat.chk_bad  = !(r_idx < r_sample_count) || (r_chunk_runs == 9'd0)
                          || (r_chunks == 11'd0);
        o_stat.run_bad  = (r_per == 32'd0) || (r_fc == 32'd0) || (nf <= {1'b0, r_fc});
        o_stat.hit      = idx64 < (r_seen + r_prod);
        o_stat.last_run = (10'(r_i) + 10'd1) >= 10'(r_chunk_runs);
        o_stat.div_last = (r_step == 6'd63);
        o_stat.base_bad = chunk_bad || (r_off_rd == 64'd0);
        o_stat.uniform  = (r_uniform != 32'd0);
        o_stat.sum_done = !(r_j < stop) && !r_pend;
        o_stat.fin_bad  = r_ovf || (r_sz == 32'd0) || ({32'd0, r_sz} > r_file_bytes)
                          || (r_at > (r_file_bytes - {32'd0, r_sz}));
        o_stat.t_more   = r_i < r_time_runs;
        o_stat.t_hit    = r_thit;
    end

    always_ff @(posedge i_clk) begin
        if (fire) r_idx <= i_slot;
        case (i_cmd.op)
            OP_CHK: begin
                r_i    <= '0;
                r_seen <= '0;
            end
            OP_RD_NXT: begin
                r_fc  <= cur_ok ? r_crun_rd[63:32] : 32'd0;
                r_per <= cur_ok ? r_crun_rd[31:0] : 32'd0;
            end
            OP_EVAL: r_prod <= {32'd0, nf[31:0] - r_fc} * {32'd0, r_per};
            OP_STEP: begin
                if (o_stat.hit) begin
                    r_dend <= idx64 - r_seen;
                    r_rem  <= '0;
                    r_step <= '0;
                end else begin
                    r_seen <= r_seen + r_prod;
                    r_i    <= r_i + 9'd1;
                end
            end
            OP_DIV: begin
                r_rem  <= div_ge ? 32'(div_t - div_d) : div_t[31:0];
                r_dend <= {r_dend[62:0], 1'b0};
                r_quo  <= {r_quo[62:0], div_ge};
                r_step <= r_step + 6'd1;
            end
            OP_CHUNK: begin
                r_chunk <= {32'd0, r_fc} + r_quo;
                r_j     <= idx64 - {32'd0, r_rem};
            end
            OP_BASE2: begin
                r_base <= r_off_rd;
                r_add  <= (r_uniform != 32'd0) ? ({32'd0, r_rem} * {32'd0, r_uniform}) : 64'd0;
                r_pend <= 1'b0;
            end
            OP_SUM: begin
                // one size read issued per cycle, summed as it returns
                if (r_j < stop) begin
                    r_j    <= r_j + 64'd1;
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
                if (r_pend) r_add <= r_add + {32'd0, r_size_rd};
            end
            OP_SZ2: begin
                if (r_uniform != 32'd0) r_sz <= r_uniform;
                else r_sz <= idx_in_size ? r_size_rd : 32'd0;
                r_at  <= r_base + r_add;
                r_ovf <= r_add > ~r_base;
            end
            OP_TINIT: begin
                r_i    <= '0;
                r_seen <= '0;
                r_tacc <= '0;
                r_thit <= 1'b0;
            end
            OP_TEV: begin
                r_thit <= t_hit;
                if (t_hit) begin
                    r_prod <= {32'd0, idx_minus} * {32'd0, t_dur};
                end else begin
                    r_prod <= {32'd0, t_cnt} * {32'd0, t_dur};
                    r_seen <= r_seen + {32'd0, t_cnt};
                    r_i    <= r_i + 9'd1;
                end
            end
            OP_TADD: r_tacc <= r_tacc + r_prod;
            OP_FIN_OK: begin
                r_found    <= 1'b1;
                r_out_off  <= r_at;
                r_out_len  <= r_sz;
                r_out_time <= r_tacc;
            end
            OP_FIN_BAD: begin
                r_found    <= 1'b0;
                r_out_off  <= '0;
                r_out_len  <= '0;
                r_out_time <= '0;
            end
            default: ;
        endcase
    end

    assign o_found         = r_found;
    assign o_sample_offset = r_out_off;
    assign o_sample_length = r_out_len;
    assign o_start_time    = r_out_time;

endmodule

### rtl/core/media_sample_table_locator_top.sv
// sample table locator: loads four tables and answers sample lookups
// input channel i_in_valid/o_in_ready carries one item: a table load (action 0..3)
// or a query (action 4) naming a sample index in i_slot
// loads write when taken and give no result; a query gives one result item on
// o_out_valid/i_out_ready with found, byte offset, length and start time
// a query walks the chunk runs, runs the one-bit-per-cycle divider, sums the
// sizes of the earlier samples of the chunk from the size memory (none with a
// uniform size), walks the time runs, plus fixed steps; misses exit early
// one item is worked at a time; the input is ready again once the result sits
// in the output register, so the next item can be taken while it waits
// a stalled receiver holds the result; a finished query then waits for it
// the config port (i_cfg_we, i_cfg_index, i_cfg_data) writes a register at once
// reset clears config registers and control; tables are undefined until loaded
module media_sample_table_locator_top
    import mstl_pkg::*;
#(
    parameter int CHUNK_RUN_DEPTH = 256,
    parameter int TIME_RUN_DEPTH  = 256,
    parameter int SIZE_DEPTH      = 4096,
    parameter int CHUNK_DEPTH     = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_slot,
    input  logic [31:0] i_word_first,
    input  logic [31:0] i_word_second,
    input  logic [63:0] i_offset_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_found,
    output logic [63:0] o_sample_offset,
    output logic [31:0] o_sample_length,
    output logic [63:0] o_start_time
);

    t_cmd  cmd;
    t_stat stat;

    mstl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    mstl_dp #(
        .CHUNK_RUN_DEPTH (CHUNK_RUN_DEPTH),
        .TIME_RUN_DEPTH  (TIME_RUN_DEPTH),
        .SIZE_DEPTH      (SIZE_DEPTH),
        .CHUNK_DEPTH     (CHUNK_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_slot          (i_slot),
        .i_word_first    (i_word_first),
        .i_word_second   (i_word_second),
        .i_offset_word   (i_offset_word),
        .o_stat          (stat),
        .o_found         (o_found),
        .o_sample_offset (o_sample_offset),
        .o_sample_length (o_sample_length),
        .o_start_time    (o_start_time)
    );

endmodule
